### rtl/core/local_azimuth_from_vectors_unit_assert.svh
// Assertion macros shared by the local azimuth unit.
`ifndef LOCAL_AZIMUTH_FROM_VECTORS_UNIT_ASSERT_SVH
`define LOCAL_AZIMUTH_FROM_VECTORS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LAFV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LAFV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lafv_pkg.sv
// Package with types, constants and the arctangent table of the local azimuth unit.
`timescale 1ns / 1ps
package lafv_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int ANGLE_BITS     = 16;
  localparam int NORM_BITS      = 20;
  localparam int CORDIC_BITS    = 30;
  localparam int CORDIC_STEPS   = 30;
  localparam int CORDIC_W       = 34;
  localparam int SPLIT          = 21;
  localparam int VLEN_W         = $clog2(COORD_WIDTH + 1);
  localparam int PLEN_W         = 7;
  localparam int SQRT_STEPS     = 22;
  localparam int SQ_W           = 44;
  localparam int D_W            = 43;
  localparam int W_W            = 43;
  localparam int ROOT_W         = 22;
  localparam int CORDIC_LATENCY = 37;

  typedef logic signed [NORM_BITS:0] comp_t;
  typedef logic [1:0] status_t;

  localparam status_t ST_NORMAL    = 2'd0;
  localparam status_t ST_POLE      = 2'd1;
  localparam status_t ST_NO_OFFSET = 2'd2;

  typedef struct packed {
    status_t                  status;
    logic signed [63:0]       x;
    logic signed [W_W-1:0]    w;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/lafv_vec_norm.sv
// Three-stage scaler that brings a 3-vector to a 20-bit largest magnitude.
`timescale 1ns / 1ps
module lafv_vec_norm (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic [2:0][lafv_pkg::COORD_WIDTH-1:0]  vec_in,
  output logic                                   out_valid,
  output lafv_pkg::comp_t [2:0]                  vec_out
);
  import lafv_pkg::*;

  logic [2:0][COORD_WIDTH-1:0] mag_r, mag_nxt, mag2_r, sh;
  logic [2:0]                  neg_r, neg_nxt, neg2_r;
  logic [COORD_WIDTH-1:0]      or_r;
  logic [VLEN_W-1:0]           len_r, len_nxt;
  logic                        v1_r, v2_r, v3_r;
  comp_t [2:0]                 out_r, out_nxt;
  logic [2:0][NORM_BITS-1:0]   m20;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_nxt[k] = vec_in[k][COORD_WIDTH-1];
      mag_nxt[k] = neg_nxt[k] ? (~vec_in[k] + 1'b1) : vec_in[k];
    end
  end

  // Bit length of the largest magnitude equals that of the OR of all of them.
  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < COORD_WIDTH; i++) begin
      if (or_r[i]) begin
        len_nxt = VLEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (len_r > VLEN_W'(NORM_BITS)) begin
        sh[k] = mag2_r[k] >> (len_r - VLEN_W'(NORM_BITS));
      end else begin
        sh[k] = mag2_r[k] << (VLEN_W'(NORM_BITS) - len_r);
      end
      m20[k]     = sh[k][NORM_BITS-1:0];
      out_nxt[k] = neg2_r[k] ? -$signed({1'b0, m20[k]}) : $signed({1'b0, m20[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    or_r   <= mag_nxt[0] | mag_nxt[1] | mag_nxt[2];
    mag2_r <= mag_r;
    neg2_r <= neg_r;
    len_r  <= len_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = v3_r;
  assign vec_out   = out_r;

endmodule

### rtl/core/lafv_geom.sv
// Four-stage product pipeline that forms the north term, the east term and |c|^2.
`timescale 1ns / 1ps
module lafv_geom (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  lafv_pkg::comp_t [2:0]       c_in,
  input  lafv_pkg::comp_t [2:0]       p_in,
  output logic                        out_valid,
  output logic [lafv_pkg::D_W-1:0]    out_d,
  output lafv_pkg::side_t             out_side
);
  import lafv_pkg::*;

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic signed [41:0]      pxy_r, pyx_r, cxx_r, cyy_r, cxp_r, cyp_r, czz_r, czz2_r;
  comp_t                   pz1_r, cz1_r, pz2_r, cz2_r;
  status_t                 st1_r, st2_r, st3_r, st4_r;
  logic signed [W_W-1:0]   w2_r, w3_r, w4_r, dot2_r;
  logic signed [D_W-1:0]   r2_r;
  logic [D_W-1:0]          d3_r, d4_r, d_nxt;
  logic signed [43:0]      rl_p_r, rh_p_r, dl_p_r, dh_p_r;
  logic signed [63:0]      x_nxt, x4_r;

  assign d_nxt = D_W'(r2_r) + D_W'(czz2_r);

  assign x_nxt = (64'(rh_p_r) <<< SPLIT) + 64'(rl_p_r)
               - (64'(dh_p_r) <<< SPLIT) - 64'(dl_p_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: the seven small products.
    pxy_r  <= c_in[0] * p_in[1];
    pyx_r  <= c_in[1] * p_in[0];
    cxx_r  <= c_in[0] * c_in[0];
    cyy_r  <= c_in[1] * c_in[1];
    cxp_r  <= c_in[0] * p_in[0];
    cyp_r  <= c_in[1] * p_in[1];
    czz_r  <= c_in[2] * c_in[2];
    pz1_r  <= p_in[2];
    cz1_r  <= c_in[2];
    st1_r  <= (c_in[0] == '0 && c_in[1] == '0) ? ST_POLE : ST_NORMAL;
    // Stage 2: sums.
    w2_r   <= W_W'(pxy_r) - W_W'(pyx_r);
    r2_r   <= D_W'(cxx_r) + D_W'(cyy_r);
    dot2_r <= W_W'(cxp_r) + W_W'(cyp_r);
    czz2_r <= czz_r;
    pz2_r  <= pz1_r;
    cz2_r  <= cz1_r;
    st2_r  <= st1_r;
    // Stage 3: wide products cut into halves, and |c|^2.
    rl_p_r <= $signed({1'b0, r2_r[SPLIT-1:0]}) * pz2_r;
    rh_p_r <= $signed({1'b0, r2_r[D_W-2:SPLIT]}) * pz2_r;
    dl_p_r <= $signed({1'b0, dot2_r[SPLIT-1:0]}) * cz2_r;
    dh_p_r <= $signed(dot2_r[W_W-1:SPLIT]) * cz2_r;
    d3_r   <= d_nxt;
    w3_r   <= w2_r;
    st3_r  <= st2_r;
    // Stage 4: north term.
    x4_r   <= x_nxt;
    d4_r   <= d3_r;
    w4_r   <= w3_r;
    st4_r  <= st3_r;
  end

  assign out_valid       = v4_r;
  assign out_d           = d4_r;
  assign out_side.status = st4_r;
  assign out_side.x      = x4_r;
  assign out_side.w      = w4_r;

endmodule

### rtl/core/lafv_isqrt.sv
// Pipelined floor square root, one result bit per stage, with sideband carried along.
`timescale 1ns / 1ps
module lafv_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [lafv_pkg::D_W-1:0]      in_d,
  input  lafv_pkg::side_t               in_side,
  output logic                          out_valid,
  output logic [lafv_pkg::ROOT_W-1:0]   out_root,
  output lafv_pkg::side_t               out_side
);
  import lafv_pkg::*;

  logic [SQ_W-1:0] rem_r  [SQRT_STEPS+1];
  logic [SQ_W-1:0] root_r [SQRT_STEPS+1];
  side_t           side_r [SQRT_STEPS+1];
  logic            vld_r  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= SQ_W'(in_d);
    root_r[0] <= '0;
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - i));
    logic [SQ_W-1:0] trial;
    assign trial = root_r[i] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      side_r[i+1] <= side_r[i];
      if (rem_r[i] >= trial) begin
        rem_r[i+1]  <= rem_r[i] - trial;
        root_r[i+1] <= (root_r[i] >> 1) + BIT;
      end else begin
        rem_r[i+1]  <= rem_r[i];
        root_r[i+1] <= root_r[i] >> 1;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STEPS];
  assign out_root  = root_r[SQRT_STEPS][ROOT_W-1:0];
  assign out_side  = side_r[SQRT_STEPS];

endmodule

### rtl/core/lafv_cordic.sv
// East scaling, pair normalization, vectoring CORDIC and output rounding.
`timescale 1ns / 1ps
module lafv_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [lafv_pkg::ROOT_W-1:0]       in_root,
  input  lafv_pkg::side_t                   in_side,
  output logic                              out_valid,
  output logic [lafv_pkg::ANGLE_BITS-1:0]   out_azimuth,
  output lafv_pkg::status_t                 out_status
);
  import lafv_pkg::*;

  localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);

  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  status_t              st1_r, st2_r, st3_r, st4_r, st5_r, sto_r;
  logic signed [45:0]   pl_r, ph_r;
  logic signed [63:0]   x1_r, x2_r, y2_r;
  logic [63:0]          mx3_r, my3_r, mx4_r, my4_r, shx, shy, mx_nxt, my_nxt;
  logic                 nx3_r, ny3_r, nx4_r, ny4_r;
  logic [63:0]          or3_r;
  logic [PLEN_W-1:0]    len4_r, len_nxt;
  logic signed [CORDIC_W-1:0] x5_r, y5_r, x5_nxt, y5_nxt;
  logic [CORDIC_BITS-1:0] mx30, my30;
  logic signed [CORDIC_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y_r [CORDIC_STEPS+1];
  logic [31:0]          a_r  [CORDIC_STEPS+1];
  status_t              st_r [CORDIC_STEPS+1];
  logic                 vld_r [CORDIC_STEPS+1];
  logic [31:0]          az_sum;
  logic [ANGLE_BITS-1:0] az_r;

  assign mx_nxt = x2_r[63] ? 64'(-x2_r) : 64'(x2_r);
  assign my_nxt = y2_r[63] ? 64'(-y2_r) : 64'(y2_r);

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < 64; i++) begin
      if (or3_r[i]) begin
        len_nxt = PLEN_W'(i + 1);
      end
    end
  end

  always_comb begin
    if (len4_r > PLEN_W'(CORDIC_BITS)) begin
      shx = mx4_r >> (len4_r - PLEN_W'(CORDIC_BITS));
      shy = my4_r >> (len4_r - PLEN_W'(CORDIC_BITS));
    end else begin
      shx = mx4_r << (PLEN_W'(CORDIC_BITS) - len4_r);
      shy = my4_r << (PLEN_W'(CORDIC_BITS) - len4_r);
    end
    mx30   = shx[CORDIC_BITS-1:0];
    my30   = shy[CORDIC_BITS-1:0];
    x5_nxt = nx4_r ? -CORDIC_W'({1'b0, mx30}) : CORDIC_W'({1'b0, mx30});
    y5_nxt = ny4_r ? -CORDIC_W'({1'b0, my30}) : CORDIC_W'({1'b0, my30});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      v4_r     <= 1'b0;
      v5_r     <= 1'b0;
      vld_r[0] <= 1'b0;
      vo_r     <= 1'b0;
    end else begin
      v1_r     <= in_valid;
      v2_r     <= v1_r;
      v3_r     <= v2_r;
      v4_r     <= v3_r;
      v5_r     <= v4_r;
      vld_r[0] <= v5_r;
      vo_r     <= vld_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    // East term times the root, cut into two halves.
    pl_r  <= $signed({1'b0, in_side.w[SPLIT-1:0]}) * $signed({1'b0, in_root});
    ph_r  <= $signed(in_side.w[W_W-1:SPLIT]) * $signed({1'b0, in_root});
    x1_r  <= in_side.x;
    st1_r <= in_side.status;
    x2_r  <= x1_r;
    y2_r  <= (64'(ph_r) <<< SPLIT) + 64'(pl_r);
    st2_r <= st1_r;
    mx3_r <= mx_nxt;
    my3_r <= my_nxt;
    nx3_r <= x2_r[63];
    ny3_r <= y2_r[63];
    or3_r <= mx_nxt | my_nxt;
    st3_r <= (st2_r == ST_NORMAL && x2_r == '0 && y2_r == '0) ? ST_NO_OFFSET : st2_r;
    mx4_r <= mx3_r;
    my4_r <= my3_r;
    nx4_r <= nx3_r;
    ny4_r <= ny3_r;
    len4_r <= len_nxt;
    st4_r <= st3_r;
    x5_r  <= x5_nxt;
    y5_r  <= y5_nxt;
    st5_r <= st4_r;
    // Left half-plane: turn by half a turn first.
    if (x5_r < 0) begin
      x_r[0] <= -x5_r;
      y_r[0] <= -y5_r;
      a_r[0] <= 32'h80000000;
    end else begin
      x_r[0] <= x5_r;
      y_r[0] <= y5_r;
      a_r[0] <= '0;
    end
    st_r[0] <= st5_r;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic [31:0] ATAN = atan_turn(i);
    logic signed [CORDIC_W-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      st_r[i+1] <= st_r[i];
      if (y_r[i] > 0) begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        a_r[i+1] <= a_r[i] + ATAN;
      end else begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        a_r[i+1] <= a_r[i] - ATAN;
      end
    end
  end

  assign az_sum = a_r[CORDIC_STEPS] + ROUND_HALF;

  always_ff @(posedge clk) begin
    sto_r <= st_r[CORDIC_STEPS];
    if (st_r[CORDIC_STEPS] == ST_NORMAL) begin
      az_r <= az_sum[31 -: ANGLE_BITS];
    end else begin
      az_r <= '0;
    end
  end

  assign out_valid   = vo_r;
  assign out_azimuth = az_r;
  assign out_status  = sto_r;

endmodule

### rtl/core/local_azimuth_from_vectors_unit.sv
// Top level of the local azimuth unit: observer and target in, azimuth and status out.
//
//   Channel  Ports                                   Handshake
//   request  start, busy, in_centre_*, in_target_*   taken when start is high, busy low
//   result   out_valid, out_azimuth, out_status      one-cycle strobe, never held off
//
// A request is taken in every cycle in which start is high; busy is always low
// because every stage moves forward on every clock. Results are strobed in
// request order, after 3 register stages of vector scaling, 4 of products,
// 23 in the square-root pipeline and 37 in the angle pipeline (scaling, 30
// CORDIC steps, rounding). Reset is synchronous and clears only the valid
// bits, so no stale result leaves the pipeline afterwards.
`timescale 1ns / 1ps
`include "local_azimuth_from_vectors_unit_assert.svh"
module local_azimuth_from_vectors_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_centre_x,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_centre_y,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_centre_z,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_target_x,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_target_y,
  input  logic signed [lafv_pkg::COORD_WIDTH-1:0]   in_target_z,
  output logic                                      out_valid,
  output logic [lafv_pkg::ANGLE_BITS-1:0]           out_azimuth,
  output logic [1:0]                                out_status
);
  import lafv_pkg::*;

  logic        req;
  logic        cv_valid, pv_valid, g_valid, sq_valid;
  comp_t [2:0] c_norm, p_norm;
  logic [D_W-1:0]    g_d;
  side_t             g_side, sq_side;
  logic [ROOT_W-1:0] sq_root;
  status_t           st_out;

  // Nothing ever stalls, so a request is taken whenever start is high.
  assign busy = 1'b0;
  assign req  = start & ~busy;

  // The observer and the target are scaled side by side with equal latency.
  lafv_vec_norm u_cnorm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req),
    .vec_in    ({in_centre_z, in_centre_y, in_centre_x}),
    .out_valid (cv_valid),
    .vec_out   (c_norm)
  );

  lafv_vec_norm u_pnorm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req),
    .vec_in    ({in_target_z, in_target_y, in_target_x}),
    .out_valid (pv_valid),
    .vec_out   (p_norm)
  );

  // North term, east term and |c|^2; the pole check is made on the scaled centre.
  lafv_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cv_valid & pv_valid),
    .c_in      (c_norm),
    .p_in      (p_norm),
    .out_valid (g_valid),
    .out_d     (g_d),
    .out_side  (g_side)
  );

  // Floor square root of |c|^2, which scales the east term.
  lafv_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_d      (g_d),
    .in_side   (g_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Angle of the (north, east) pair, rounded to the output resolution.
  lafv_cordic u_cordic (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sq_valid),
    .in_root     (sq_root),
    .in_side     (sq_side),
    .out_valid   (out_valid),
    .out_azimuth (out_azimuth),
    .out_status  (st_out)
  );

  assign out_status = st_out;

  // A flagged result always carries a zero azimuth.
  `LAFV_ASSERT_NOW(a_flag_zero, clk, rst_n, out_valid && st_out != ST_NORMAL, out_azimuth == '0, "flagged result with nonzero azimuth")
  // Only the three defined status codes leave the block.
  `LAFV_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, st_out == ST_NORMAL || st_out == ST_POLE || st_out == ST_NO_OFFSET, "undefined status code")
  // Every result traces back to a root that left the square-root pipeline.
  `LAFV_ASSERT_NOW(a_angle_latency, clk, rst_n, out_valid, $past(sq_valid, CORDIC_LATENCY), "result without matching root")

endmodule
